>>> rtl/sglm_pkg.sv
// Shared types and constants for the sequence gap loss monitor.
package sglm_pkg;

  localparam int SEQ_W   = 32;
  localparam int LOSS_W  = 48;
  localparam int PCT_W   = 7;
  localparam int NUM_W   = 55;
  localparam int DEN_W   = 39;
  localparam int ENTRY_W = 96;
  localparam logic [PCT_W-1:0] PERCENT_FULL = 7'd100;
  localparam logic [SEQ_W-1:0] WINDOW_RESET = 32'd2000;

  // Classified request kind.
  typedef enum logic {
    KIND_PACKET = 1'b0,
    KIND_TICK   = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t       kind;
    logic [SEQ_W-1:0] seq;
  } item_t;

  // Percent divider request and response.
  typedef struct packed {
    logic              start;
    logic [LOSS_W-1:0] lost;
    logic [SEQ_W-1:0]  span;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] pct;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_RD,
    ST_ACC,
    ST_DIV_CUR,
    ST_WAIT_CUR,
    ST_WAIT_AVG,
    ST_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHK,
    DV_STEP
  } div_state_t;

endpackage

>>> rtl/sequence_gap_loss_monitor_unit.sv
// Top level of the sequence gap loss monitor.
//
// Each request is a packet sequence number or a one-tick time advance, and each
// gives one result: windowed loss percent, average loss percent and a flag for a
// newly recorded gap. Requests enter a two-entry queue and are handled one at a
// time by a sequencer. Each request walks the N history entries held (at most
// HISTORY_DEPTH-1) through the history RAM's single read port, then makes two
// percent divisions in the shared one-bit-per-cycle divider, which finishes
// early when a percent is zero or clamps to one hundred.
// The history RAM needs no clearing after reset.
module sequence_gap_loss_monitor_unit #(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [31:0] in_sequence_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_current_loss_percent,
  output logic [6:0]  out_average_loss_percent,
  output logic        out_gap_recorded
);

  import sglm_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  sglm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_sequence_req (in_sequence_req),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  sglm_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_write_en             (cfg_write_en),
    .cfg_write_data           (cfg_write_data),
    .q_valid                  (q_valid),
    .q_item                   (q_item),
    .q_pop                    (q_pop),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_current_loss_percent (out_current_loss_percent),
    .out_average_loss_percent (out_average_loss_percent),
    .out_gap_recorded         (out_gap_recorded)
  );

  // The back end only takes a request that the queue holds.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("queue popped while empty");

  // Percents never exceed one hundred.
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_current_loss_percent <= PERCENT_FULL &&
                   out_average_loss_percent <= PERCENT_FULL))
    else $error("percent out of range");

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid &&
                                  $stable(out_current_loss_percent) &&
                                  $stable(out_average_loss_percent) &&
                                  $stable(out_gap_recorded)))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

>>> rtl/sglm_ram.sv
// Generic single write port RAM with a registered read port.
module sglm_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/sglm_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module sglm_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_opcode,
  input  logic [31:0]            in_sequence_req,
  output logic                   q_valid,
  output sglm_pkg::item_t        q_item,
  input  logic                   q_pop
);

  import sglm_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  item_t      cls;

  // The queue is full when both slots hold a request.
  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];

  // Classify the incoming request.
  always_comb begin
    cls.kind = in_opcode ? KIND_TICK : KIND_PACKET;
    cls.seq  = in_sequence_req;
  end

  // Payload slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !q_pop) begin
        count_r <= count_r + 2'd1;
      end else if (!push && q_pop) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

>>> rtl/sglm_div.sv
// Percent unit: lost * 100 / span, clamped to 0..100, one quotient bit a cycle.
module sglm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  sglm_pkg::div_req_t req,
  output sglm_pkg::div_rsp_t rsp
);

  import sglm_pkg::*;

  div_state_t        state_r;
  div_state_t        state_nxt;
  logic [NUM_W-1:0]  num_r;
  logic [SEQ_W-1:0]  den_r;
  logic              zero_r;
  logic [2:0]        bit_r;
  logic [PCT_W-1:0]  q_r;
  logic              done_r;
  logic [PCT_W-1:0]  pct_r;
  logic [NUM_W-1:0]  num_x;
  logic [DEN_W-1:0]  den_x;
  logic [DEN_W-1:0]  den101;
  logic [DEN_W-1:0]  den_sh;
  logic              fits;

  // Numerator times 100 by shifts and adds.
  assign num_x = {1'b0, req.lost, 6'b0} + {2'b0, req.lost, 5'b0} + {5'b0, req.lost, 2'b0};
  assign den_x  = {7'b0, den_r};
  assign den101 = {den_x[DEN_W-7:0], 6'b0} + {den_x[DEN_W-6:0], 5'b0}
                + {den_x[DEN_W-3:0], 2'b0} + den_x;
  assign den_sh = den_x << bit_r;
  assign fits   = num_r >= {{(NUM_W-DEN_W){1'b0}}, den_sh};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DV_IDLE: if (req.start) state_nxt = DV_CHK;
      DV_CHK: begin
        if (zero_r || num_r >= {{(NUM_W-DEN_W){1'b0}}, den101}) begin
          state_nxt = DV_IDLE;
        end else begin
          state_nxt = DV_STEP;
        end
      end
      DV_STEP: if (bit_r == 3'd0) state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath; the result is flagged for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        DV_IDLE: begin
          if (req.start) begin
            num_r  <= num_x;
            den_r  <= req.span;
            zero_r <= req.lost[LOSS_W-1] || (req.lost == '0) || (req.span == '0);
          end
        end
        DV_CHK: begin
          bit_r <= 3'd6;
          q_r   <= '0;
          if (zero_r) begin
            done_r <= 1'b1;
            pct_r  <= '0;
          end else if (num_r >= {{(NUM_W-DEN_W){1'b0}}, den101}) begin
            done_r <= 1'b1;
            pct_r  <= PERCENT_FULL;
          end
        end
        DV_STEP: begin
          if (fits) begin
            num_r <= num_r - {{(NUM_W-DEN_W){1'b0}}, den_sh};
          end
          q_r[bit_r] <= fits;
          bit_r      <= bit_r - 3'd1;
          if (bit_r == 3'd0) begin
            done_r <= 1'b1;
            pct_r  <= {q_r[PCT_W-1:1], fits};
          end
        end
        default: done_r <= 1'b0;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.pct  = pct_r;

endmodule

>>> rtl/sglm_back.sv
// Back end: applies each request to the state, walks the gap history and forms results.
module sglm_back #(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_write_en,
  input  logic [31:0]            cfg_write_data,
  input  logic                   q_valid,
  input  sglm_pkg::item_t        q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [6:0]             out_current_loss_percent,
  output logic [6:0]             out_average_loss_percent,
  output logic                   out_gap_recorded
);

  import sglm_pkg::*;

  localparam int IDX_W = $clog2(HISTORY_DEPTH);

  back_state_t       state_r;
  back_state_t       state_nxt;
  logic [SEQ_W-1:0]  window_r;
  logic              seen_r;
  logic [SEQ_W-1:0]  last_r;
  logic [SEQ_W-1:0]  start_r;
  logic [LOSS_W-1:0] total_r;
  logic [SEQ_W-1:0]  now_r;
  logic [IDX_W-1:0]  head_r;
  logic [IDX_W-1:0]  tail_r;
  logic [IDX_W-1:0]  idx_r;
  logic              first_r;
  logic [SEQ_W-1:0]  tail_seq_r;
  logic [LOSS_W-1:0] sum_r;
  logic              rec_r;
  logic [PCT_W-1:0]  cur_r;
  logic [PCT_W-1:0]  avg_r;
  logic              out_valid_r;
  logic [PCT_W-1:0]  out_cur_r;
  logic [PCT_W-1:0]  out_avg_r;
  logic              out_rec_r;

  logic              is_gap;
  logic [SEQ_W-1:0]  gap;
  logic [IDX_W-1:0]  head_next;
  logic              ram_we;
  logic              ram_re;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [SEQ_W-1:0]  e_seq;
  logic [SEQ_W-1:0]  e_loss;
  logic [SEQ_W-1:0]  e_time;
  logic [IDX_W-1:0]  idx_next;
  logic              out_free;
  div_req_t          dreq;
  div_rsp_t          drsp;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    ring_next = (i == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // Gap detection for the request at the head of the queue.
  assign gap       = q_item.seq - last_r - 32'd1;
  assign is_gap    = (q_item.kind == KIND_PACKET) && seen_r && (q_item.seq != last_r + 32'd1);
  assign head_next = ring_next(head_r);
  assign idx_next  = ring_next(idx_r);
  assign ram_wdata = {last_r, gap, now_r};
  assign {e_seq, e_loss, e_time} = ram_rdata;
  assign out_free  = !out_valid_r || !out_stall;

  sglm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  sglm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (q_valid) state_nxt = ST_CHK;
      ST_CHK:      state_nxt = (head_r == tail_r) ? ST_DIV_CUR : ST_RD;
      ST_RD:       state_nxt = ST_ACC;
      ST_ACC:      state_nxt = (idx_next == head_r) ? ST_DIV_CUR : ST_RD;
      ST_DIV_CUR:  state_nxt = ST_WAIT_CUR;
      ST_WAIT_CUR: if (drsp.done) state_nxt = ST_WAIT_AVG;
      ST_WAIT_AVG: if (drsp.done) state_nxt = ST_OUT;
      ST_OUT:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    dreq.start = 1'b0;
    dreq.lost  = sum_r;
    dreq.span  = last_r - tail_seq_r;
    case (state_r)
      ST_IDLE: begin
        q_pop  = q_valid;
        ram_we = q_valid && is_gap;
      end
      ST_RD:      ram_re = 1'b1;
      ST_DIV_CUR: dreq.start = 1'b1;
      ST_WAIT_CUR: begin
        dreq.start = drsp.done;
        dreq.lost  = total_r;
        dreq.span  = last_r - start_r;
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Architectural state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      seen_r   <= 1'b0;
      last_r   <= '0;
      start_r  <= '0;
      total_r  <= '0;
      now_r    <= '0;
      head_r   <= '0;
      tail_r   <= '0;
    end else begin
      if (cfg_write_en) begin
        window_r <= cfg_write_data;
      end
      if (state_r == ST_IDLE && q_valid) begin
        if (q_item.kind == KIND_TICK) begin
          now_r <= now_r + 32'd1;
        end else if (!seen_r) begin
          start_r <= q_item.seq;
          last_r  <= q_item.seq;
          seen_r  <= 1'b1;
        end else begin
          if (is_gap) begin
            total_r <= total_r + {{(LOSS_W-SEQ_W){gap[SEQ_W-1]}}, gap};
            head_r  <= head_next;
            if (head_next == tail_r) begin
              tail_r <= ring_next(tail_r);
            end
          end
          last_r <= q_item.seq;
        end
      end
    end
  end

  // Walk and percent datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        rec_r   <= is_gap;
        sum_r   <= '0;
        first_r <= 1'b1;
      end
      ST_CHK: idx_r <= tail_r;
      ST_ACC: begin
        if (first_r) begin
          tail_seq_r <= e_seq;
        end
        first_r <= 1'b0;
        if ((now_r - e_time) <= window_r) begin
          sum_r <= sum_r + {{(LOSS_W-SEQ_W){e_loss[SEQ_W-1]}}, e_loss};
        end
        idx_r <= idx_next;
      end
      ST_WAIT_CUR: if (drsp.done) cur_r <= drsp.pct;
      ST_WAIT_AVG: if (drsp.done) avg_r <= drsp.pct;
      default: first_r <= first_r;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
      out_cur_r   <= cur_r;
      out_avg_r   <= avg_r;
      out_rec_r   <= rec_r;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_current_loss_percent = out_cur_r;
  assign out_average_loss_percent = out_avg_r;
  assign out_gap_recorded         = out_rec_r;

endmodule
